[hw/rtl/tns_pkg.sv]
// ----------------------------------------------------------------------------
// tns_pkg
// Shared types and constants for the tone note sequencer.
// ----------------------------------------------------------------------------
package tns_pkg;

    localparam int FREQ_W      = 20;
    localparam int DUR_W       = 16;
    localparam int CLK_W       = 30;
    localparam int RELOAD_W    = 29;
    localparam int MS_W        = 32;
    localparam int ENTRY_W     = DUR_W + FREQ_W;
    localparam int DIVISOR_W   = FREQ_W + 1;
    localparam int DIV_STEPS   = CLK_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // word index of the timer clock register
    localparam logic REG_TIMER_CLOCK = 1'b0;

    localparam logic [CLK_W-1:0] TIMER_CLOCK_RST = CLK_W'(170000000);

    typedef enum logic [1:0] {
        OP_ENQUEUE  = 2'd0,
        OP_TICK     = 2'd1,
        OP_FLUSH    = 2'd2,
        OP_SET_FREQ = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SERV,
        ST_POP,
        ST_TONE,
        ST_DIV,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[hw/rtl/tns_ram.sv]
// ----------------------------------------------------------------------------
// tns_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/tns_div.sv]
// ----------------------------------------------------------------------------
// tns_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tns_div
    import tns_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CLK_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic [CLK_W-1:0]     quotient,
    output div_stat_t            stat
);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DIVISOR_W-1:0] rem_reg,   rem_next;
    logic [CLK_W-1:0]     quo_reg,   quo_next;
    logic [DIVISOR_W-1:0] dsr_reg,   dsr_next;

    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_sub;
    logic                 fits;

    // shift in the next dividend bit, trial subtract
    assign rem_shift = {rem_reg, quo_reg[CLK_W-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_next = {quo_reg[CLK_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[hw/rtl/tone_note_sequencer_core.sv]
// ----------------------------------------------------------------------------
// tone_note_sequencer_core
// Tone player fed by a ring FIFO of notes (frequency, duration).
// Input channel (in_valid/in_ready) carries one item: operation, frequency,
// duration_ms. Operations: enqueue a note, 1 ms tick and service, flush,
// set frequency directly (0 mutes). Every item gives one result item on the
// output channel (out_valid/out_ready): accepted, tone_active,
// current_frequency, reload_value, queue_empty.
// One item is worked at a time. After accept, enqueue and flush pass
// EXEC then DONE; a tick goes EXEC, SERV and, when it pops, POP and
// TONE; set frequency goes EXEC, TONE; a sounding tone adds DIV before
// DONE. The next item is taken once the result is in the output register.
// The tone reload is found by a bit-serial divider, one quotient bit per
// cycle over the 30-bit timer clock; that makes sounding tones the longest.
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled receiver holds the block in its done state only
// once that register is still full.
// Reset: FIFO empty, muted, counters zero, timer clock 170 MHz. The note
// store is not cleared; no clearing pass is needed.
// timer_clock_hz lives at APB byte address 0.
// ----------------------------------------------------------------------------
module tone_note_sequencer_core
    import tns_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            operation,
    input  logic [FREQ_W-1:0]     frequency,
    input  logic [DUR_W-1:0]      duration_ms,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  accepted,
    output logic                  tone_active,
    output logic [FREQ_W-1:0]     current_frequency,
    output logic [RELOAD_W-1:0]   reload_value,
    output logic                  queue_empty,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    // ---------------- state ----------------
    seq_state_t          state_reg, state_next;

    op_t                 op_reg,       op_next;
    logic [FREQ_W-1:0]   freq_reg,     freq_next;
    logic [DUR_W-1:0]    dur_reg,      dur_next;
    logic [FREQ_W-1:0]   tone_f_reg,   tone_f_next;   // tone being applied
    logic                acc_reg,      acc_next;

    logic [QW-1:0]       wr_idx_reg,   wr_idx_next;
    logic [QW-1:0]       rd_idx_reg,   rd_idx_next;
    logic                running_reg,  running_next;
    logic [FREQ_W-1:0]   sf_reg,       sf_next;       // sounding frequency
    logic [RELOAD_W-1:0] reload_reg,   reload_next;
    logic [MS_W-1:0]     ms_reg,       ms_next;
    logic [MS_W-1:0]     deadline_reg, deadline_next;
    logic [CLK_W-1:0]    clk_hz_reg,   clk_hz_next;

    logic                out_valid_reg, out_valid_next;
    logic                o_acc_reg;
    logic                o_active_reg;
    logic [FREQ_W-1:0]   o_freq_reg;
    logic [RELOAD_W-1:0] o_reload_reg;
    logic                o_empty_reg;

    // ---------------- helpers ----------------
    logic                in_fire;
    logic                out_load;
    logic                cfg_write;
    logic [QW-1:0]       wr_idx_inc;
    logic [QW-1:0]       rd_idx_inc;
    logic                fifo_empty;
    logic                fifo_full;
    logic [MS_W-1:0]     late_diff;
    logic                deadline_hit;
    logic                pop_now;
    logic [FREQ_W:0]     tone_twice;
    logic                tone_mute;

    logic                ram_we;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [FREQ_W-1:0]   entry_freq;
    logic [DUR_W-1:0]    entry_dur;

    logic                div_start;
    logic [CLK_W-1:0]    div_quo;
    div_stat_t           div_stat;

    assign in_fire   = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign wr_idx_inc = (wr_idx_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx_inc = (rd_idx_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
    assign fifo_empty = (wr_idx_reg == rd_idx_reg);
    assign fifo_full  = (wr_idx_inc == rd_idx_reg);

    // wrapping deadline: passed when (now - deadline) is non-negative
    assign late_diff    = ms_reg - deadline_reg;
    assign deadline_hit = ~late_diff[MS_W-1];
    assign pop_now      = (!running_reg || deadline_hit) && !fifo_empty;

    assign tone_twice = {tone_f_reg, 1'b0};
    assign tone_mute  = (tone_f_reg == '0) || (CLK_W'(tone_twice) > clk_hz_reg);

    assign entry_freq = ram_rdata[FREQ_W-1:0];
    assign entry_dur  = ram_rdata[ENTRY_W-1:FREQ_W];

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_TICK:     state_next = ST_SERV;
                    OP_SET_FREQ: state_next = ST_TONE;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_SERV:
            begin
                state_next = pop_now ? ST_POP : ST_DONE;
            end
            ST_POP:
            begin
                state_next = ST_TONE;
            end
            ST_TONE:
            begin
                state_next = tone_mute ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- state machine outputs ----------------
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready  = 1'b1;
            ST_EXEC: ram_we    = (op_reg == OP_ENQUEUE) && !fifo_full;
            ST_SERV: ram_re    = pop_now;
            ST_TONE: div_start = !tone_mute;
            ST_DONE: out_load  = !out_valid_reg || out_ready;
            default: in_ready  = 1'b0;
        endcase
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        op_next       = op_reg;
        freq_next     = freq_reg;
        dur_next      = dur_reg;
        tone_f_next   = tone_f_reg;
        acc_next      = acc_reg;
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        running_next  = running_reg;
        sf_next       = sf_reg;
        reload_next   = reload_reg;
        ms_next       = ms_reg;
        deadline_next = deadline_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next   = op_t'(operation);
                    freq_next = frequency;
                    dur_next  = duration_ms;
                end
            end
            ST_EXEC:
            begin
                acc_next = 1'b1;
                case (op_reg)
                    OP_ENQUEUE:
                    begin
                        if (fifo_full)
                        begin
                            acc_next = 1'b0;
                        end
                        else
                        begin
                            wr_idx_next = wr_idx_inc;
                        end
                    end
                    OP_TICK:
                    begin
                        ms_next = ms_reg + 1'b1;
                    end
                    OP_FLUSH:
                    begin
                        wr_idx_next  = '0;
                        rd_idx_next  = '0;
                        running_next = 1'b0;
                        sf_next      = '0;
                    end
                    OP_SET_FREQ:
                    begin
                        tone_f_next = freq_reg;
                    end
                    default:
                    begin
                        acc_next = 1'b1;
                    end
                endcase
            end
            ST_SERV:
            begin
                // tone ran out and nothing left to play
                if (running_reg && deadline_hit && fifo_empty)
                begin
                    running_next = 1'b0;
                    sf_next      = '0;
                end
            end
            ST_POP:
            begin
                rd_idx_next   = rd_idx_inc;
                deadline_next = ms_reg + MS_W'(entry_dur);
                tone_f_next   = entry_freq;
            end
            ST_TONE:
            begin
                // zero or out-of-range tone: stop the timer, keep reload
                if (tone_mute)
                begin
                    running_next = 1'b0;
                    sf_next      = '0;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    reload_next  = RELOAD_W'(div_quo - 1'b1);
                    running_next = 1'b1;
                    sf_next      = tone_f_reg;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // ---------------- config register ----------------
    always_comb
    begin
        clk_hz_next = clk_hz_reg;
        if (cfg_write && (paddr[2] == REG_TIMER_CLOCK))
        begin
            clk_hz_next = pwdata[CLK_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMER_CLOCK) ? APB_DATA_W'(clk_hz_reg) : '0;

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= 1'b1;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            running_reg   <= 1'b0;
            sf_reg        <= '0;
            reload_reg    <= '0;
            ms_reg        <= '0;
            deadline_reg  <= '0;
            clk_hz_reg    <= TIMER_CLOCK_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            running_reg   <= running_next;
            sf_reg        <= sf_next;
            reload_reg    <= reload_next;
            ms_reg        <= ms_next;
            deadline_reg  <= deadline_next;
            clk_hz_reg    <= clk_hz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        freq_reg   <= freq_next;
        dur_reg    <= dur_next;
        tone_f_reg <= tone_f_next;
        if (out_load)
        begin
            o_acc_reg    <= acc_reg;
            o_active_reg <= running_reg;
            o_freq_reg   <= sf_reg;
            o_reload_reg <= reload_reg;
            o_empty_reg  <= fifo_empty;
        end
    end

    assign out_valid         = out_valid_reg;
    assign accepted          = o_acc_reg;
    assign tone_active       = o_active_reg;
    assign current_frequency = o_freq_reg;
    assign reload_value      = o_reload_reg;
    assign queue_empty       = o_empty_reg;

    // ---------------- note store ----------------
    tns_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_note_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_idx_reg),
        .wr_data ({dur_reg, freq_reg}),
        .rd_en   (ram_re),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rdata)
    );

    // ---------------- reload divider ----------------
    tns_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clk_hz_reg),
        .divisor  (tone_twice),
        .quotient (div_quo),
        .stat     (div_stat)
    );

`ifndef SYNTHESIS
    // a sounding tone always has a nonzero frequency
    a_active_freq: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (sf_reg != '0))
        else $error("tone running with zero frequency");

    // the divider only works while the sequencer waits on it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> (state_reg == ST_DIV))
        else $error("divider active outside divide state");

    // flush leaves the FIFO empty
    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && op_reg == OP_FLUSH) |=> fifo_empty)
        else $error("flush did not empty the FIFO");

    // a pop only follows a read of a non-empty FIFO
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> ($past(ram_re) && !$past(fifo_empty)))
        else $error("pop without a valid read");
`endif

endmodule
